/* rtl/core/tabw_pkg.sv */
// Shared types, register indexes and constants of the texture addressing core.
package tabw_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int MAX_CANVAS_LOG2_DEF = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  localparam logic [CFG_INDEX_W-1:0] REG_ADDR_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CANVAS_W    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CANVAS_H    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_W_LOG2 = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_H_LOG2 = 3'd5;

  localparam logic [3:0]  TILE_LOG2_MAX = 4'd12;
  localparam logic [3:0]  TILE_LOG2_RST = 4'd6;
  localparam logic [16:0] W_ONE         = 17'h10000;
  localparam logic [16:0] W_HALF        = 17'h08000;
  localparam logic [1:0]  CORNER_LAST   = 2'd3;

  typedef struct packed {
    logic signed [31:0] coord_u;
    logic signed [31:0] coord_v;
  } in_item_t;

  typedef struct packed {
    logic [15:0] tile_col;
    logic [15:0] tile_row;
    logic [11:0] texel_col;
    logic [11:0] texel_row;
    logic [16:0] weight;
    logic [1:0]  corner;
    logic        last;
  } out_item_t;

  // Load enables of the three front stages.
  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
  } stage_ctl_t;

endpackage

/* rtl/core/tabw_axis.sv */
// One coordinate axis: address, scale by the canvas size, texel index and weight.
module tabw_axis import tabw_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int MAX_CANVAS_LOG2 = MAX_CANVAS_LOG2_DEF,
  parameter bit FLIP            = 1'b0
) (
  input  logic                       clk,
  input  stage_ctl_t                 ctl,
  input  logic signed [31:0]         coord,
  input  logic                       wrap,
  input  logic                       bilin,
  input  logic [MAX_CANVAS_LOG2:0]   size,
  output logic [MAX_CANVAS_LOG2-1:0] idx0,
  output logic [MAX_CANVAS_LOG2-1:0] idx1,
  output logic [15:0]                wfrac
);

  localparam int F = COORD_FRAC_BITS;
  localparam int M = MAX_CANVAS_LOG2;
  localparam int P = F + M + 2;
  localparam logic [33:0] ONE = 34'd1 << F;

  logic signed [33:0] c_ext;
  logic signed [33:0] pos;
  logic [F:0]         p_nxt;
  logic [F:0]         p_r;
  logic [M:0]         mul_op;
  logic [P-1:0]       prod_nxt;
  logic [P-1:0]       prod_r;
  logic [M:0]         size_m1;
  logic [M+1:0]       idx_raw;
  logic [M-1:0]       idx_cl;
  logic [M:0]         idx_inc;
  logic [M-1:0]       idx_far;
  logic [15:0]        frac_q16;
  logic [M-1:0]       idx0_r;
  logic [M-1:0]       idx1_r;
  logic [15:0]        wfrac_r;

  // Stage 1: flip when FLIP is set, then clamp to [0, one] or wrap into [0, one).
  assign c_ext = {{2{coord[31]}}, coord};
  assign pos   = FLIP ? ($signed(ONE) - c_ext) : c_ext;

  always_comb begin
    if (wrap) begin
      p_nxt = {1'b0, pos[F-1:0]};
    end else if (pos[33]) begin
      p_nxt = '0;
    end else if (pos > $signed(ONE)) begin
      p_nxt = ONE[F:0];
    end else begin
      p_nxt = pos[F:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      p_r <= p_nxt;
    end
  end

  // Stage 2: scale by size in nearest mode, by size minus one in bilinear mode.
  assign size_m1  = size - 1'b1;
  assign mul_op   = bilin ? size_m1 : size;
  assign prod_nxt = P'(p_r) * P'(mul_op);

  always_ff @(posedge clk) begin
    if (ctl.s2_en) begin
      prod_r <= prod_nxt;
    end
  end

  // Stage 3: integer part gives the near texel, the fraction the far weight.
  assign idx_raw = prod_r[P-1:F];
  assign idx_cl  = (idx_raw > (M+2)'(size_m1)) ? size_m1[M-1:0] : idx_raw[M-1:0];
  assign idx_inc = {1'b0, idx_cl} + 1'b1;

  always_comb begin
    if (idx_inc > size_m1) begin
      idx_far = wrap ? '0 : size_m1[M-1:0];
    end else begin
      idx_far = idx_inc[M-1:0];
    end
  end

  generate
    if (F >= 16) begin : g_frac_trunc
      assign frac_q16 = prod_r[F-1 -: 16];
    end else begin : g_frac_ext
      assign frac_q16 = {prod_r[F-1:0], {(16-F){1'b0}}};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (ctl.s3_en) begin
      idx0_r  <= idx_cl;
      idx1_r  <= idx_far;
      wfrac_r <= frac_q16;
    end
  end

  assign idx0  = idx0_r;
  assign idx1  = idx1_r;
  assign wfrac = wfrac_r;

endmodule

/* rtl/core/tabw_emit.sv */
// Corner sequencer: holds one texel neighborhood and issues one result beat a cycle while it holds one.
module tabw_emit import tabw_pkg::*; #(
  parameter int MAX_CANVAS_LOG2 = MAX_CANVAS_LOG2_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  output logic                       take,
  input  logic [MAX_CANVAS_LOG2-1:0] x0,
  input  logic [MAX_CANVAS_LOG2-1:0] x1,
  input  logic [MAX_CANVAS_LOG2-1:0] y0,
  input  logic [MAX_CANVAS_LOG2-1:0] y1,
  input  logic [15:0]                wx1,
  input  logic [15:0]                wy1,
  input  logic                       bilin,
  input  logic [3:0]                 tile_w_log2,
  input  logic [3:0]                 tile_h_log2,
  output logic                       res_vld,
  output out_item_t                  res
);

  localparam int M = MAX_CANVAS_LOG2;

  logic         hold_vld_r, hold_vld_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic [M-1:0] x0_r, x1_r, y0_r, y1_r;
  logic [15:0]  wx1_r, wy1_r;
  logic         done;
  logic [M-1:0] xs, ys;
  logic [M-1:0] mask_x, mask_y;
  logic [16:0]  wa, wb;
  logic [33:0]  wprod;
  logic [33:0]  wsum;
  out_item_t    res_nxt;
  out_item_t    res_r;
  logic         res_vld_r;

  assign done = hold_vld_r & (~bilin | (cnt_r == CORNER_LAST));
  assign take = ~hold_vld_r | done;

  always_comb begin
    hold_vld_nxt = take ? in_vld : hold_vld_r;
    cnt_nxt      = take ? 2'd0 : cnt_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      cnt_r      <= 2'd0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_vld) begin
      x0_r  <= x0;
      x1_r  <= x1;
      y0_r  <= y0;
      y1_r  <= y1;
      wx1_r <= wx1;
      wy1_r <= wy1;
    end
  end

  // Bit 0 of the corner picks the right column, bit 1 the lower row.
  assign xs = cnt_r[0] ? x1_r : x0_r;
  assign ys = cnt_r[1] ? y1_r : y0_r;
  assign wa = cnt_r[0] ? {1'b0, wx1_r} : W_ONE - {1'b0, wx1_r};
  assign wb = cnt_r[1] ? {1'b0, wy1_r} : W_ONE - {1'b0, wy1_r};
  assign wprod = 34'(wa) * 34'(wb);
  assign wsum  = wprod + 34'(W_HALF);

  assign mask_x = ~({M{1'b1}} << tile_w_log2);
  assign mask_y = ~({M{1'b1}} << tile_h_log2);

  always_comb begin
    res_nxt.tile_col  = 16'(xs >> tile_w_log2);
    res_nxt.tile_row  = 16'(ys >> tile_h_log2);
    res_nxt.texel_col = 12'(xs & mask_x);
    res_nxt.texel_row = 12'(ys & mask_y);
    res_nxt.weight    = bilin ? wsum[32:16] : W_ONE;
    res_nxt.corner    = cnt_r;
    res_nxt.last      = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= hold_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule

/* rtl/core/texture_address_bilinear_weights_core.sv */
// Top level of the texture coordinate addressing and bilinear weight core.
//
//   channel  ports                              handshake
//   input    start, busy, in_data               beat taken when start and not busy
//   result   out_valid, out_data                one beat per cycle, no stall
//   config   cfg_valid, cfg_ready, cfg_index,   write when valid and ready
//            cfg_data
//
// Nearest mode takes one coordinate per cycle; in bilinear mode the corner
// sequencer, which issues one result per cycle, takes a new coordinate only
// as it issues the last of the four corners of the one it holds. Reset is
// synchronous and clears all valid bits and the registers to their
// defaults. The front stages stall behind the sequencer and busy rises when
// stage one cannot move.
module texture_address_bilinear_weights_core import tabw_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int MAX_CANVAS_LOG2 = MAX_CANVAS_LOG2_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  in_item_t               in_data,
  output logic                   out_valid,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int M = MAX_CANVAS_LOG2;
  localparam logic [CFG_DATA_W-1:0] SIZE_MAX = CFG_DATA_W'(1) << M;

  logic         wrap_r;
  logic         bilin_r;
  logic [M:0]   size_w_r, size_h_r;
  logic [3:0]   tile_w_r, tile_h_r;
  logic [M:0]   size_wr;
  logic [3:0]   tile_wr;

  logic         s1_vld_r, s2_vld_r, s3_vld_r;
  logic         s1_free, s2_free, s3_free;
  logic         accept;
  logic         emit_take;
  stage_ctl_t   ctl;

  logic [M-1:0] x0, x1, y0, y1;
  logic [15:0]  wx1, wy1;

  // Sizes and tile shifts are saturated as they are written.
  always_comb begin
    if (cfg_data == '0) begin
      size_wr = (M+1)'(1);
    end else if (cfg_data > SIZE_MAX) begin
      size_wr = SIZE_MAX[M:0];
    end else begin
      size_wr = cfg_data[M:0];
    end
    tile_wr = (cfg_data[3:0] > TILE_LOG2_MAX) ? TILE_LOG2_MAX : cfg_data[3:0];
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r   <= 1'b0;
      bilin_r  <= 1'b0;
      size_w_r <= (M+1)'(256);
      size_h_r <= (M+1)'(256);
      tile_w_r <= TILE_LOG2_RST;
      tile_h_r <= TILE_LOG2_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ADDR_MODE:   wrap_r   <= cfg_data[0];
        REG_FILTER_MODE: bilin_r  <= cfg_data[0];
        REG_CANVAS_W:    size_w_r <= size_wr;
        REG_CANVAS_H:    size_h_r <= size_wr;
        REG_TILE_W_LOG2: tile_w_r <= tile_wr;
        REG_TILE_H_LOG2: tile_h_r <= tile_wr;
        default: ;
      endcase
    end
  end

  assign s3_free = ~s3_vld_r | emit_take;
  assign s2_free = ~s2_vld_r | s3_free;
  assign s1_free = ~s1_vld_r | s2_free;
  assign busy    = ~s1_free;
  assign accept  = start & s1_free;

  assign ctl.s1_en = accept;
  assign ctl.s2_en = s2_free;
  assign ctl.s3_en = s3_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (s1_free) s1_vld_r <= accept;
      if (s2_free) s2_vld_r <= s1_vld_r;
      if (s3_free) s3_vld_r <= s2_vld_r;
    end
  end

  tabw_axis #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .MAX_CANVAS_LOG2(MAX_CANVAS_LOG2),
    .FLIP(1'b0)
  ) u_axis_u (
    .clk   (clk),
    .ctl   (ctl),
    .coord (in_data.coord_u),
    .wrap  (wrap_r),
    .bilin (bilin_r),
    .size  (size_w_r),
    .idx0  (x0),
    .idx1  (x1),
    .wfrac (wx1)
  );

  tabw_axis #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .MAX_CANVAS_LOG2(MAX_CANVAS_LOG2),
    .FLIP(1'b1)
  ) u_axis_v (
    .clk   (clk),
    .ctl   (ctl),
    .coord (in_data.coord_v),
    .wrap  (wrap_r),
    .bilin (bilin_r),
    .size  (size_h_r),
    .idx0  (y0),
    .idx1  (y1),
    .wfrac (wy1)
  );

  tabw_emit #(
    .MAX_CANVAS_LOG2(MAX_CANVAS_LOG2)
  ) u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (s3_vld_r),
    .take        (emit_take),
    .x0          (x0),
    .x1          (x1),
    .y0          (y0),
    .y1          (y1),
    .wx1         (wx1),
    .wy1         (wy1),
    .bilin       (bilin_r),
    .tile_w_log2 (tile_w_r),
    .tile_h_log2 (tile_h_r),
    .res_vld     (out_valid),
    .res         (out_data)
  );

endmodule

/* rtl/core/tabw_checker.sv */
// Port-level checks of the addressing core and the bind that attaches them.
module tabw_checker import tabw_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_data
);

  // A reset leaves the core empty and ready for a new beat.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("core not idle after reset");

  // The corners of one coordinate come out on consecutive cycles.
  a_corner_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |=> out_valid)
    else $error("gap inside a corner sequence");

  a_corner_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |=>
      (out_data.corner == $past(out_data.corner) + 2'd1))
    else $error("corner order broken");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.weight <= W_ONE))
    else $error("weight above one");

  // A single-beat result is a nearest texel with full weight.
  a_nearest_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last && out_data.corner == 2'd0) |->
      (out_data.weight == W_ONE))
    else $error("nearest result without full weight");

endmodule

bind texture_address_bilinear_weights_core tabw_checker u_tabw_checker (.*);

/* verif/tb_top.sv */
// Self-checking testbench of the texture coordinate addressing and bilinear weight core.
`timescale 1ns / 100ps

import tabw_pkg::*;

localparam logic ADDR_CLAMP      = 1'b0;
localparam logic ADDR_WRAP       = 1'b1;
localparam logic FILTER_NEAREST  = 1'b0;
localparam logic FILTER_BILINEAR = 1'b1;

localparam logic [1:0] CORNER_TOP_LEFT = 2'd0;
localparam logic [1:0] CORNER_RIGHT    = 2'd1;
localparam logic [1:0] CORNER_BELOW    = 2'd2;
localparam logic [1:0] CORNER_DIAG     = CORNER_LAST;

// Indexes past the last register; writes to them must change nothing.
localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

class bilinear_footprint;
  logic        addr_mode;
  logic        filt_mode;
  logic [16:0] canvas_w;
  logic [16:0] canvas_h;
  logic [3:0]  tile_w_log2;
  logic [3:0]  tile_h_log2;
  out_item_t   due_texels[$];
  int          errors;

  function new();
    addr_mode   = ADDR_CLAMP;
    filt_mode   = FILTER_NEAREST;
    canvas_w    = 17'd256;
    canvas_h    = 17'd256;
    tile_w_log2 = TILE_LOG2_RST;
    tile_h_log2 = TILE_LOG2_RST;
    errors      = 0;
  endfunction

  function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_ADDR_MODE:   addr_mode = d[0];
      REG_FILTER_MODE: filt_mode = d[0];
      REG_CANVAS_W:    canvas_w = d;
      REG_CANVAS_H:    canvas_h = d;
      REG_TILE_W_LOG2: tile_w_log2 = d[3:0];
      REG_TILE_H_LOG2: tile_h_log2 = d[3:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return due_texels.size();
  endfunction

  function longint unsigned fit_size(logic [16:0] s);
    if (s == 0) return 1;
    if (s > (17'd1 << MAX_CANVAS_LOG2_DEF)) return 64'd1 << MAX_CANVAS_LOG2_DEF;
    return s;
  endfunction

  function longint unsigned fit_log2(logic [3:0] l);
    return (l > TILE_LOG2_MAX) ? TILE_LOG2_MAX : l;
  endfunction

  // Clamp to [0, one] or wrap into [0, one) in Q16.16.
  function longint unsigned fold(longint p);
    if (addr_mode == ADDR_WRAP) return p & 64'hFFFF;
    if (p < 0) return 0;
    if (p > 65536) return 65536;
    return p;
  endfunction

  function longint unsigned far_texel(longint unsigned i, longint unsigned size);
    if (i + 1 > size - 1) return (addr_mode == ADDR_WRAP) ? 0 : size - 1;
    return i + 1;
  endfunction

  function longint unsigned blend(longint unsigned a, longint unsigned b);
    return (a * b + W_HALF) >> 16;
  endfunction

  function void push_texel(longint unsigned x, longint unsigned y, longint unsigned w,
                           logic [1:0] corner, logic last);
    out_item_t       t;
    longint unsigned lx;
    longint unsigned ly;
    lx          = fit_log2(tile_w_log2);
    ly          = fit_log2(tile_h_log2);
    t.tile_col  = 16'(x >> lx);
    t.tile_row  = 16'(y >> ly);
    t.texel_col = 12'(x & ((64'd1 << lx) - 1));
    t.texel_row = 12'(y & ((64'd1 << ly) - 1));
    t.weight    = 17'(w);
    t.corner    = corner;
    t.last      = last;
    due_texels.push_back(t);
  endfunction

  function void note_coord(in_item_t it);
    longint unsigned w, h, pu, pv, su, sv, x0, y0, x1, y1, wx0, wx1, wy0, wy1;
    w  = fit_size(canvas_w);
    h  = fit_size(canvas_h);
    pu = fold(longint'($signed(it.coord_u)));
    // v is flipped before addressing.
    pv = fold(longint'(65536) - longint'($signed(it.coord_v)));
    if (filt_mode == FILTER_NEAREST) begin
      x0 = (pu * w) >> 16;
      y0 = (pv * h) >> 16;
      if (x0 > w - 1) x0 = w - 1;
      if (y0 > h - 1) y0 = h - 1;
      push_texel(x0, y0, W_ONE, CORNER_TOP_LEFT, 1'b1);
    end else begin
      su  = pu * (w - 1);
      sv  = pv * (h - 1);
      x0  = su >> 16;
      y0  = sv >> 16;
      wx1 = su & 64'hFFFF;
      wy1 = sv & 64'hFFFF;
      wx0 = W_ONE - wx1;
      wy0 = W_ONE - wy1;
      if (x0 > w - 1) x0 = w - 1;
      if (y0 > h - 1) y0 = h - 1;
      x1 = far_texel(x0, w);
      y1 = far_texel(y0, h);
      push_texel(x0, y0, blend(wx0, wy0), CORNER_TOP_LEFT, 1'b0);
      push_texel(x1, y0, blend(wx1, wy0), CORNER_RIGHT, 1'b0);
      push_texel(x0, y1, blend(wx0, wy1), CORNER_BELOW, 1'b0);
      push_texel(x1, y1, blend(wx1, wy1), CORNER_DIAG, 1'b1);
    end
  endfunction

  function void cmp_field(string name, longint unsigned exp, longint unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, actual %0d", name, exp, act);
      errors++;
    end
  endfunction

  function void check_texel(out_item_t got);
    out_item_t exp;
    if (due_texels.size() == 0) begin
      $error("texel result with nothing expected: %p", got);
      errors++;
      return;
    end
    exp = due_texels.pop_front();
    cmp_field("tile_col", exp.tile_col, got.tile_col);
    cmp_field("tile_row", exp.tile_row, got.tile_row);
    cmp_field("texel_col", exp.texel_col, got.texel_col);
    cmp_field("texel_row", exp.texel_row, got.texel_row);
    cmp_field("weight", exp.weight, got.weight);
    cmp_field("corner", exp.corner, got.corner);
    cmp_field("last", exp.last, got.last);
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 36;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  in_item_t               in_data = '0;
  logic                   out_valid;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  bilinear_footprint fp;
  int                idle_pct = 0;
  int                burst_left = 0;
  int                cycles = 0;

  texture_address_bilinear_weights_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) fp.check_texel(out_data);
  end

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    fp.set_reg(idx, d);
  endtask

  // Mode and log2 registers get random upper bits, which the block must drop.
  task automatic program_setup(logic addr, logic filt, logic [16:0] cw, logic [16:0] ch,
                               logic [3:0] tw, logic [3:0] th);
    logic [CFG_DATA_W-1:0] d;
    d = 17'($urandom); d[0] = addr;
    cfg_write(REG_ADDR_MODE, d);
    cfg_write(REG_SPARE_A, 17'($urandom));
    d = 17'($urandom); d[0] = filt;
    cfg_write(REG_FILTER_MODE, d);
    cfg_write(REG_CANVAS_W, cw);
    cfg_write(REG_CANVAS_H, ch);
    d = 17'($urandom); d[3:0] = tw;
    cfg_write(REG_TILE_W_LOG2, d);
    cfg_write(REG_SPARE_B, 17'($urandom));
    d = 17'($urandom); d[3:0] = th;
    cfg_write(REG_TILE_H_LOG2, d);
    cfg_valid <= 1'b0;
  endtask

  task automatic hold_off();
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 31) == 0) begin
      burst_left = $urandom_range(4, 16);
    end else begin
      while ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // Start stays high on return so back-to-back beats need no second assignment.
  task automatic send_coord(logic [31:0] u, logic [31:0] v);
    in_item_t it;
    it.coord_u = u;
    it.coord_v = v;
    hold_off();
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    fp.note_coord(it);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return $urandom;
      6: return ($urandom_range(0, 1) ? 32'h10000 : 32'h0) + 32'($urandom_range(0, 8)) - 32'd4;
      7: return 32'($urandom_range(0, 32'h10000));
      default: return 32'($urandom_range(0, 32'h50000)) - 32'h20000;
    endcase
  endfunction

  task automatic run_random(int n);
    repeat (n) send_coord(pick_coord(), pick_coord());
  endtask

  // Edges of [0, one], the sign extremes, half and quarter points and just-past-edge values.
  task automatic run_edge_coords();
    send_coord(32'h0000_0000, 32'h0000_0000);
    send_coord(32'h0001_0000, 32'h0001_0000);
    send_coord(32'h7FFF_FFFF, 32'h8000_0000);
    send_coord(32'h8000_0000, 32'h7FFF_FFFF);
    send_coord(32'hFFFF_FFFF, 32'h0000_0001);
    send_coord(32'h0000_8000, 32'h0000_8000);
    send_coord(32'h0000_FFFF, 32'h0001_0001);
    send_coord(32'h0001_8000, 32'hFFFF_8000);
    send_coord(32'h0001_0001, 32'h0000_FFFF);
    send_coord(32'h0000_4000, 32'h0000_C000);
  endtask

  // Every item yields a result, but clock the pipeline for DRAIN_CYCLES past the last one.
  task automatic settle();
    int n;
    n = 0;
    start <= 1'b0;
    while (fp.pending() != 0 && n < SETTLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [16:0] pick_canvas();
    case ($urandom_range(0, 3))
      0: return 17'($urandom_range(1, 16));
      1: return 17'd1 << $urandom_range(0, 16);
      default: return 17'($urandom_range(0, 17'h1FFFF));
    endcase
  endfunction

  initial begin
    fp = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 0;
    run_edge_coords();
    run_random(PHASE_ITEMS);
    settle();

    program_setup(ADDR_WRAP, FILTER_BILINEAR, 17'd200, 17'd100, 4'd3, 4'd4);
    idle_pct = 79;
    run_edge_coords();
    run_random(PHASE_ITEMS);
    settle();

    program_setup(ADDR_WRAP, FILTER_BILINEAR, 17'd1, 17'd65536, 4'd0, 4'd12);
    idle_pct = 0;
    run_random(PHASE_ITEMS);
    settle();

    program_setup(ADDR_CLAMP, FILTER_BILINEAR, 17'd65536, 17'd1, 4'd12, 4'd0);
    idle_pct = 17;
    run_random(PHASE_ITEMS);
    settle();

    // Out-of-range sizes and tile shifts saturate inside the block.
    program_setup(ADDR_WRAP, FILTER_NEAREST, 17'd0, 17'h1FFFF, 4'd15, 4'd13);
    idle_pct = 0;
    run_random(PHASE_ITEMS);
    settle();

    program_setup(ADDR_CLAMP, FILTER_BILINEAR, 17'h1FFFF, 17'd0, 4'd13, 4'd15);
    idle_pct = 79;
    run_random(PHASE_ITEMS);
    settle();

    for (int p = 0; p < 4; p++) begin
      program_setup(1'($urandom), 1'($urandom), pick_canvas(), pick_canvas(),
                    4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      idle_pct = (p == 1) ? 79 : (p == 3) ? 17 : 0;
      run_random(PHASE_ITEMS);
      settle();
    end

    if (fp.pending() != 0) begin
      $error("%0d texel results never arrived", fp.pending());
      fp.errors++;
    end
    if (fp.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/tabw_pkg.sv
rtl/core/tabw_axis.sv
rtl/core/tabw_emit.sv
rtl/core/texture_address_bilinear_weights_core.sv
rtl/core/tabw_checker.sv
verif/tb_top.sv
